// ===== rtl/ksl_pkg.sv =====
// Shared types and constants for the string loop: field widths, op and
// register codes, loop filter and feedback constants, sequencer states.
// No dependencies.
package ksl_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int CFG_W               = 13;
   localparam int OP_W                = 2;
   localparam int CSR_ADDR_W          = 2;
   localparam int MAX_LINE_LENGTH_DEF = 4096;

   // op codes carried in tuser
   localparam logic [OP_W-1:0] OP_PROCESS = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DAMPING     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STIFFNESS   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY       = 2'd3;

   localparam int LINE_LENGTH_RESET = 2;
   localparam int CONFIG_ONE        = 4096;
   localparam int COEF_MIN          = 1638;
   localparam int COEF_MAX          = 31130;
   localparam int COEF_HALF         = 16384;
   localparam int COEF_DAMP         = 11469;
   localparam int COEF_STIFF        = 8192;
   localparam int FB_BASE           = 27853;
   localparam int FB_SPAN           = 4882;
   localparam int Q15_ONE           = 32768;
   localparam int Q15_HALF          = 16384;
   localparam int Q12_HALF          = 2048;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GAIN,
      ST_FINISH
   } ksl_state_type;

endpackage

// ===== rtl/ksl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ksl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/karplus_strong_string_loop.sv =====
// Karplus-Strong string loop: delay line in ksl_ram, one-pole lowpass and
// feedback gain in a small multi-cycle sequencer. Depends on ksl_pkg, ksl_ram.
//
// Usage:
//   req channel: tuser = op (process, load excitation, restart), tdata = Q1.15
//   sample. rsp channel: one item per request, tdata = Q1.15 delay line output
//   on process, zero for the other ops. csr port: write-only, index 0 line
//   length, 1 damping, 2 stiffness, 3 decay (Q12); write only while idle.
//   Throughput: one request at a time. A process item runs from accept
//   through the RAM read, multiply and round for the lowpass, multiply by
//   the feedback gain and write-back before the next accept; load, restart
//   and the unused op go from accept straight to write-back. The result
//   shows on rsp at the edge of its write-back.
//   Reset: after reset the delay line is swept to zero, one entry a cycle,
//   across MAX_LINE_LENGTH entries (4096 by default); req_tready stays low
//   meanwhile, csr writes are taken. Position and lowpass state reset to zero.
//   Stall: the result sits in an output register; the next item is accepted
//   while it waits, and that item's write-back holds until the slot is free.
module karplus_strong_string_loop
   import ksl_pkg::*;
#(
   parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] sample_in
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] op
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // [15:0] sample_out
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_LINE_LENGTH);
   localparam int LEN_W  = ADDR_W + 1;
   localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

   // configuration registers
   logic [CFG_W-1:0] line_length_ff, damping_ff, stiffness_ff, decay_ff;

   // control state
   ksl_state_type state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic signed [SAMPLE_W-1:0] lp_ff, lp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // item and datapath registers
   logic [OP_W-1:0]            op_ff, op_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic signed [SAMPLE_W-1:0] stored_ff, stored_in;
   logic signed [32:0]         p1_ff, p1_in, p2_ff, p2_in;
   logic signed [SAMPLE_W-1:0] lp_new_ff, lp_new_in;
   logic signed [31:0]         p3_ff, p3_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [14:0]                coef_ff, coef_in, gain_ff, gain_in;

   // RAM port
   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

   ksl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LINE_LENGTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_in),
      .rd_data (ram_rdata)
   );

   // effective line length, clamped to [2, MAX_LINE_LENGTH]
   logic [CMP_W-1:0] ll_ext;
   logic [LEN_W-1:0] len_eff;
   logic [ADDR_W-1:0] pos_eff;
   logic [LEN_W-1:0] pos_next;

   always_comb begin
      ll_ext = CMP_W'(line_length_ff);
      if (ll_ext < CMP_W'(2)) begin
         len_eff = LEN_W'(2);
      end else if (ll_ext > CMP_W'(MAX_LINE_LENGTH)) begin
         len_eff = LEN_W'(MAX_LINE_LENGTH);
      end else begin
         len_eff = LEN_W'(ll_ext);
      end
      // position left beyond a shortened line wraps to zero
      pos_eff  = ({1'b0, pos_ff} < len_eff) ? pos_ff : '0;
      pos_next = {1'b0, addr_ff} + LEN_W'(1);
   end

   // lowpass coefficient and feedback gain from the settings
   logic [CFG_W-1:0] damp_sat, stiff_sat, decay_sat, decay_rest;
   logic [27:0] coef_t, coef_r;
   logic [24:0] fb_t;

   always_comb begin
      damp_sat   = (damping_ff > CFG_W'(CONFIG_ONE)) ? CFG_W'(CONFIG_ONE) : damping_ff;
      stiff_sat  = (stiffness_ff > CFG_W'(CONFIG_ONE)) ? CFG_W'(CONFIG_ONE) : stiffness_ff;
      decay_sat  = (decay_ff > CFG_W'(CONFIG_ONE)) ? CFG_W'(CONFIG_ONE) : decay_ff;
      decay_rest = CFG_W'(CONFIG_ONE) - decay_sat;

      coef_t = 28'(COEF_HALF * CONFIG_ONE)
             + 28'(COEF_DAMP) * 28'(damp_sat)
             - 28'(COEF_STIFF) * 28'(stiff_sat);
      coef_r = (coef_t + 28'(Q12_HALF)) >> 12;
      if (coef_t < 28'(COEF_MIN * CONFIG_ONE)) begin
         coef_in = 15'(COEF_MIN);
      end else if (coef_r > 28'(COEF_MAX)) begin
         coef_in = 15'(COEF_MAX);
      end else begin
         coef_in = coef_r[14:0];
      end

      fb_t    = 25'(FB_SPAN) * 25'(decay_rest) + 25'(Q12_HALF);
      gain_in = 15'(FB_BASE) + 15'(fb_t >> 12);
   end

   // arithmetic helpers for the sequencer
   logic [15:0]         one_minus_c;
   logic signed [33:0]  lp_sum, lp_sum_r;
   logic signed [32:0]  p3_r;
   logic signed [17:0]  wr_sum;
   logic signed [SAMPLE_W-1:0] wr_sat;
   logic                out_free;

   always_comb begin
      one_minus_c = 16'(Q15_ONE) - {1'b0, coef_ff};
      lp_sum   = 34'(p1_ff) + 34'(p2_ff);
      // round half away from zero, then shift by 15
      lp_sum_r = lp_sum + (lp_sum[33] ? 34'sd16383 : 34'(Q15_HALF));
      p3_r     = 33'(p3_ff) + (p3_ff[31] ? 33'sd16383 : 33'(Q15_HALF));
      wr_sum   = 18'(x_ff) + 18'(p3_r >>> 15);
      if (wr_sum > 18'sd32767) begin
         wr_sat = 16'sh7fff;
      end else if (wr_sum < -18'sd32768) begin
         wr_sat = 16'sh8000;
      end else begin
         wr_sat = wr_sum[15:0];
      end
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // sequencer: next state, datapath and RAM controls
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      clr_addr_in  = clr_addr_ff;
      lp_in        = lp_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      addr_in      = addr_ff;
      stored_in    = stored_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      lp_new_in    = lp_new_ff;
      p3_in        = p3_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_LINE_LENGTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            addr_in    = pos_eff;
            if (req_tvalid) begin
               op_in  = req_tuser;
               x_in   = req_tdata;
               ram_re = 1'b1;
               state_in = (req_tuser == OP_PROCESS) ? ST_MUL : ST_FINISH;
            end
         end
         ST_MUL: begin
            stored_in = ram_rdata;
            p1_in     = $signed(ram_rdata) * $signed({1'b0, one_minus_c});
            p2_in     = lp_ff * $signed({1'b0, coef_ff});
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            lp_new_in = lp_sum_r[30:15];
            state_in  = ST_GAIN;
         end
         ST_GAIN: begin
            p3_in    = lp_new_ff * $signed({1'b0, gain_ff});
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
               case (op_ff)
                  OP_PROCESS, OP_LOAD: begin
                     ram_we    = 1'b1;
                     ram_wdata = (op_ff == OP_PROCESS) ? wr_sat : x_ff;
                     pos_in    = (pos_next >= len_eff) ? '0 : pos_next[ADDR_W-1:0];
                     if (op_ff == OP_PROCESS) begin
                        lp_in       = lp_new_ff;
                        rsp_data_in = stored_ff;
                     end
                  end
                  OP_RESTART: begin
                     pos_in = '0;
                     lp_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         pos_ff         <= '0;
         clr_addr_ff    <= '0;
         lp_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         line_length_ff <= CFG_W'(LINE_LENGTH_RESET);
         damping_ff     <= '0;
         stiffness_ff   <= '0;
         decay_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         clr_addr_ff  <= clr_addr_in;
         lp_ff        <= lp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_LINE_LENGTH: line_length_ff <= csr_wdata;
               CSR_DAMPING:     damping_ff     <= csr_wdata;
               CSR_STIFFNESS:   stiffness_ff   <= csr_wdata;
               CSR_DECAY:       decay_ff       <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      addr_ff     <= addr_in;
      stored_ff   <= stored_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      lp_new_ff   <= lp_new_in;
      p3_ff       <= p3_in;
      rsp_data_ff <= rsp_data_in;
      coef_ff     <= coef_in;
      gain_ff     <= gain_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
